### hw/rtl/stbs_pkg.sv
// ============================================================================
// stbs_pkg: shared types and codes for the sorted key table search unit
// Command codes and the key memory control struct.
// ============================================================================
package stbs_pkg;

    // Command codes carried on cmd
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // Key memory port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

### hw/rtl/stbs_key_mem.sv
// ============================================================================
// stbs_key_mem: key storage for the sorted table
// One write port and one read port with registered read data.
// ============================================================================
module stbs_key_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 8
) (
    input  logic                  clk,
    input  stbs_pkg::mem_ctl_t    ctl,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [WIDTH-1:0]      rd_data
);
    import stbs_pkg::*;

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Store appended keys
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the probed key
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/sorted_table_binary_search_unit.sv
// ============================================================================
// sorted_table_binary_search_unit: sorted key table with halving search
// Clear, append and search commands over a table of ascending keys; a search
// returns a found flag and the match index or the insertion position.
// ============================================================================
//
//  channel   handshake          payload
//  -------   ----------------   -------------------------
//  command   start / busy       cmd[1:0], key[31:0]
//  result    done (one cycle)   found, position[8:0]
//
//  Clear and append complete in the cycle they are accepted; busy stays low.
//  A search makes P probes, at most ceil(log2(n+1)) for n keys held, and
//  returns its result as soon as a probe hits or once the bounds cross after
//  every probe has missed. Each probe is one registered read of the key
//  memory issued in the S_PROBE state followed by a compare in the S_CMP state.
//  rst_n clears the key count and the sequencer; stored keys are not cleared.
//  done is a one-cycle strobe; the receiver cannot stall it.
// ============================================================================
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_WIDTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [31:0] key,
    output logic        done,
    output logic        found,
    output logic [8:0]  position
);
    import stbs_pkg::*;

    localparam int CW     = $clog2(TABLE_DEPTH + 2);
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        mid_reg, mid_next;
    logic [KEY_WIDTH-1:0] skey_reg, skey_next;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic [8:0]           pos_reg, pos_next;

    logic [KEY_WIDTH+31:0] key_wide;
    logic [KEY_WIDTH-1:0]  key_m;
    logic                  accept;
    logic [CW:0]           mid_sum;
    logic [CW-1:0]         mid_calc;
    logic [CW-1:0]         pos_val;
    logic [CW+8:0]         pos_wide;
    logic [KEY_WIDTH-1:0]  rd_data;
    mem_ctl_t              mem_ctl;

    // Trim or extend the key port to the key width
    assign key_wide = {{KEY_WIDTH{1'b0}}, key};
    assign key_m    = key_wide[KEY_WIDTH-1:0];
    assign accept   = start && !busy;

    // Probe index: (lo + hi) / 2 - 1
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CW:1] - {{(CW-1){1'b0}}, 1'b1};

    // Insertion position after the last probe missed
    assign pos_val  = (hi_reg <= mid_reg) ? mid_reg
                                          : mid_reg + {{(CW-1){1'b0}}, 1'b1};

    // Memory port controls
    always_comb
    begin
        mem_ctl.wr_en = accept && (cmd == CMD_APPEND)
                        && (count_reg < CW'(TABLE_DEPTH));
        mem_ctl.rd_en = (state_reg == S_PROBE) && (lo_reg <= hi_reg);
    end

    stbs_key_mem #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (KEY_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_key_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (key_m),
        .rd_addr (mid_calc[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Sequence commands and search probes
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        skey_next  = skey_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        pos_next   = pos_reg;
        pos_wide   = {9'd0, pos_val};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < CW'(TABLE_DEPTH))
                            begin
                                count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
                            end
                        end
                        CMD_SEARCH:
                        begin
                            lo_next    = {{(CW-1){1'b0}}, 1'b1};
                            hi_next    = count_reg;
                            mid_next   = '0;
                            skey_next  = key_m;
                            state_next = S_PROBE;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_PROBE:
            begin
                if (lo_reg <= hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    pos_next   = pos_wide[8:0];
                    state_next = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (rd_data > skey_reg)
                begin
                    hi_next    = mid_reg;
                    state_next = S_PROBE;
                end
                else if (rd_data < skey_reg)
                begin
                    lo_next    = mid_reg + CW'(2);
                    state_next = S_PROBE;
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    pos_wide   = {9'd0, mid_reg};
                    pos_next   = pos_wide[8:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Search bounds and result payload
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        skey_reg  <= skey_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = pos_reg;

endmodule
